// ----- design/atpc_pkg.sv -----
package atpc_pkg;

  localparam int SENSOR_BITS_DEF = 12;

  localparam int ZERO_W     = 12;
  localparam int SCALE_W    = 24;
  localparam int TICK_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int DELTA_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int TURN_W  = 16;
  localparam int COUNT_W = 32;
  localparam int ANGLE_W = 40;
  localparam int ERR_W   = 41;
  localparam int DERIV_W = 42;
  localparam int INTEG_W = 48;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 66;
  localparam int CHUNK_W = 24;

  localparam int DEG_FULL_TURN = 360;

  localparam int OUT_W = ((1 + LIMIT_W + 2 * ANGLE_W + 7) / 8) * 8;

  localparam logic [ZERO_W-1:0]  ZERO_POSITION_RST = ZERO_W'(0);
  localparam logic [SCALE_W-1:0] MOTOR_SCALE_RST   = SCALE_W'(28598);
  localparam logic [TICK_W-1:0]  TICK_SECONDS_RST  = TICK_W'(131);
  localparam logic [GAIN_W-1:0]  GAIN_P_RST        = GAIN_W'(768);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST        = GAIN_W'(128);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST        = GAIN_W'(0);
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST   = LIMIT_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_POSITION = 3'd0,
    CFG_MOTOR_SCALE   = 3'd1,
    CFG_TICK_SECONDS  = 3'd2,
    CFG_GAIN_P        = 3'd3,
    CFG_GAIN_I        = 3'd4,
    CFG_GAIN_D        = 3'd5,
    CFG_DRIVE_LIMIT   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [ZERO_W-1:0]  zero_position;
    logic [SCALE_W-1:0] motor_scale;
    logic [TICK_W-1:0]  tick_seconds;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TARGET,
    MUL_MEASURED,
    MUL_ERR_LO_T,
    MUL_ERR_HI_T,
    MUL_ERR_LO_P,
    MUL_ERR_HI_P,
    MUL_DER_LO,
    MUL_DER_HI,
    MUL_INT_LO,
    MUL_INT_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic     ld_item;
    logic     ld_target;
    logic     ld_measured;
    logic     ld_err;
    logic     ld_deriv;
    logic     ld_integral;
    logic     ld_out;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } dp_cmd_t;

endpackage

// ----- design/angle_tracking_pid_controller.sv -----
// Channel   Dir  Fields (tdata from bit 0 up)
// s_axis    in   sensor_angle, encoder_delta, zero pad to whole bytes
// m_axis    out  direction, drive_width, target_angle, measured_angle
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// Each item steps through the controller states from acceptance to its result in the output register;
// ten products go through one shared 33 x 25 multiplier.
// s_tready is high only while the block is idle, so items are taken one at a time.
// A finished result waits in the last state until the output register is free.
// Reset is synchronous and restores the register defaults and all tracking state.
module angle_tracking_pid_controller #(
  parameter int SENSOR_BITS = atpc_pkg::SENSOR_BITS_DEF,
  localparam int IN_W = ((SENSOR_BITS + atpc_pkg::DELTA_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sensor_angle, encoder_delta
  input  logic [IN_W-1:0]                  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // direction, drive_width, target_angle, measured_angle
  output logic [atpc_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [atpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import atpc_pkg::*;

  cfg_t                       cfg;
  dp_cmd_t                    cmd;
  logic [SENSOR_BITS-1:0]     sensor_angle;
  logic signed [DELTA_W-1:0]  encoder_delta;
  logic                       direction;
  logic [LIMIT_W-1:0]         drive_width;
  logic signed [ANGLE_W-1:0]  target_angle;
  logic signed [ANGLE_W-1:0]  measured_angle;

  assign sensor_angle  = s_tdata[SENSOR_BITS-1:0];
  assign encoder_delta = s_tdata[SENSOR_BITS+DELTA_W-1:SENSOR_BITS];
  assign m_tdata       = OUT_W'({measured_angle, target_angle, drive_width, direction});

  atpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  atpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  atpc_dp #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .sensor_angle   (sensor_angle),
    .encoder_delta  (encoder_delta),
    .direction      (direction),
    .drive_width    (drive_width),
    .target_angle   (target_angle),
    .measured_angle (measured_angle)
  );

endmodule

// ----- design/atpc_cfg.sv -----
module atpc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [atpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output atpc_pkg::cfg_t                   cfg
);
  import atpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_position <= ZERO_POSITION_RST;
      cfg.motor_scale   <= MOTOR_SCALE_RST;
      cfg.tick_seconds  <= TICK_SECONDS_RST;
      cfg.gain_p        <= GAIN_P_RST;
      cfg.gain_i        <= GAIN_I_RST;
      cfg.gain_d        <= GAIN_D_RST;
      cfg.drive_limit   <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZERO_POSITION: cfg.zero_position <= cfg_data[ZERO_W-1:0];
        CFG_MOTOR_SCALE:   cfg.motor_scale   <= cfg_data[SCALE_W-1:0];
        CFG_TICK_SECONDS:  cfg.tick_seconds  <= cfg_data[TICK_W-1:0];
        CFG_GAIN_P:        cfg.gain_p        <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:        cfg.gain_i        <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:        cfg.gain_d        <= cfg_data[GAIN_W-1:0];
        CFG_DRIVE_LIMIT:   cfg.drive_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/atpc_ctrl.sv -----
module atpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output atpc_pkg::dp_cmd_t cmd
);
  import atpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TMUL,
    S_MMUL,
    S_MEAS,
    S_ERR,
    S_DERIV,
    S_I_HI,
    S_I_ACC,
    S_INTEG,
    S_D_LO,
    S_D_HI,
    S_G_LO,
    S_G_HI,
    S_G_ACC,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.mul_sel = MUL_TARGET;
        state_next  = S_MMUL;
      end
      S_MMUL: begin
        cmd.ld_target = 1'b1;
        cmd.mul_sel   = MUL_MEASURED;
        state_next    = S_MEAS;
      end
      S_MEAS: begin
        cmd.ld_measured = 1'b1;
        state_next      = S_ERR;
      end
      S_ERR: begin
        cmd.ld_err = 1'b1;
        state_next = S_DERIV;
      end
      S_DERIV: begin
        cmd.ld_deriv = 1'b1;
        cmd.mul_sel  = MUL_ERR_LO_T;
        state_next   = S_I_HI;
      end
      S_I_HI: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_ERR_HI_T;
        state_next  = S_I_ACC;
      end
      S_I_ACC: begin
        cmd.acc_op  = ACC_ADD_HI;
        cmd.mul_sel = MUL_ERR_LO_P;
        state_next  = S_INTEG;
      end
      S_INTEG: begin
        cmd.ld_integral = 1'b1;
        cmd.acc_op      = ACC_LOAD;
        cmd.mul_sel     = MUL_ERR_HI_P;
        state_next      = S_D_LO;
      end
      S_D_LO: begin
        cmd.acc_op  = ACC_ADD_HI;
        cmd.mul_sel = MUL_DER_LO;
        state_next  = S_D_HI;
      end
      S_D_HI: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MUL_DER_HI;
        state_next  = S_G_LO;
      end
      S_G_LO: begin
        cmd.acc_op  = ACC_ADD_HI;
        cmd.mul_sel = MUL_INT_LO;
        state_next  = S_G_HI;
      end
      S_G_HI: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MUL_INT_HI;
        state_next  = S_G_ACC;
      end
      S_G_ACC: begin
        cmd.acc_op = ACC_ADD_HI;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/atpc_dp.sv -----
module atpc_dp #(
  parameter int SENSOR_BITS = atpc_pkg::SENSOR_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  atpc_pkg::dp_cmd_t                        cmd,
  input  atpc_pkg::cfg_t                           cfg,
  input  logic [SENSOR_BITS-1:0]                   sensor_angle,
  input  logic signed [atpc_pkg::DELTA_W-1:0]      encoder_delta,
  output logic                                     direction,
  output logic [atpc_pkg::LIMIT_W-1:0]             drive_width,
  output logic signed [atpc_pkg::ANGLE_W-1:0]      target_angle,
  output logic signed [atpc_pkg::ANGLE_W-1:0]      measured_angle
);
  import atpc_pkg::*;

  localparam int SHIFT = 16 - SENSOR_BITS;
  localparam int RAW_W = SENSOR_BITS + TURN_W + 1;
  localparam logic [SENSOR_BITS:0] HALF = (SENSOR_BITS + 1)'(1) << (SENSOR_BITS - 1);
  localparam logic signed [TURN_W-1:0]  TURN_MAX  = {1'b0, {(TURN_W - 1){1'b1}}};
  localparam logic signed [TURN_W-1:0]  TURN_MIN  = {1'b1, {(TURN_W - 1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W - 1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W - 1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W - 1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W - 1){1'b0}}};

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-ANGLE_W:0] top;
    top = v[ACC_W-1:ANGLE_W-1];
    if ((&top) || !(|top)) begin
      sat_angle = v[ANGLE_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat_angle = {1'b1, {(ANGLE_W - 1){1'b0}}};
    end else begin
      sat_angle = {1'b0, {(ANGLE_W - 1){1'b1}}};
    end
  endfunction

  logic [SENSOR_BITS-1:0]       previous_reading;
  logic                         have_previous;
  logic signed [TURN_W-1:0]     turn_offset;
  logic signed [COUNT_W-1:0]    encoder_total;
  logic signed [ERR_W-1:0]      last_error;
  logic signed [INTEG_W-1:0]    error_integral;

  logic [SENSOR_BITS-1:0]       reading;
  logic signed [ANGLE_W-1:0]    target;
  logic signed [ANGLE_W-1:0]    measured;
  logic signed [ERR_W-1:0]      err;
  logic signed [DERIV_W-1:0]    deriv;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc;

  logic [15:0]                  zero_ext;
  logic [SENSOR_BITS-1:0]       zero;
  logic [SENSOR_BITS-1:0]       prev_cmp;
  logic [SENSOR_BITS:0]         drop;
  logic [SENSOR_BITS:0]         rise;
  logic signed [TURN_W-1:0]     turn_next;
  logic signed [COUNT_W:0]      count_sum;
  logic signed [COUNT_W-1:0]    count_next;
  logic signed [RAW_W-1:0]      target_raw;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]      prod_ext;
  logic signed [ACC_W-1:0]      target_shifted;
  logic signed [INTEG_W:0]      integ_sum;
  logic signed [INTEG_W-1:0]    integ_next;
  logic [ACC_W-1:0]             magnitude;
  logic [ACC_W-CHUNK_W-1:0]     width_full;
  logic [LIMIT_W-1:0]           width_sat;

  assign zero_ext = 16'(cfg.zero_position);
  assign zero     = zero_ext[SENSOR_BITS-1:0];
  assign prev_cmp = have_previous ? previous_reading : zero;
  assign drop     = {1'b0, prev_cmp} - {1'b0, sensor_angle};
  assign rise     = {1'b0, sensor_angle} - {1'b0, prev_cmp};

  always_comb begin
    turn_next = turn_offset;
    if (sensor_angle < prev_cmp && drop > HALF) begin
      if (turn_offset != TURN_MAX) begin
        turn_next = turn_offset + TURN_W'(1);
      end
    end else if (prev_cmp < sensor_angle && rise > HALF) begin
      if (turn_offset != TURN_MIN) begin
        turn_next = turn_offset - TURN_W'(1);
      end
    end
  end

  assign count_sum = (COUNT_W + 1)'(encoder_total) + (COUNT_W + 1)'(encoder_delta);

  always_comb begin
    if (count_sum[COUNT_W] != count_sum[COUNT_W-1]) begin
      count_next = count_sum[COUNT_W] ? COUNT_MIN : COUNT_MAX;
    end else begin
      count_next = count_sum[COUNT_W-1:0];
    end
  end

  assign target_raw = RAW_W'($signed({1'b0, reading})) - RAW_W'($signed({1'b0, zero}))
                    + (RAW_W'(turn_offset) <<< SENSOR_BITS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_TARGET: begin
        mul_a = MUL_A_W'(target_raw);
        mul_b = MUL_B_W'(DEG_FULL_TURN);
      end
      MUL_MEASURED: begin
        mul_a = MUL_A_W'(encoder_total);
        mul_b = MUL_B_W'($signed({1'b0, cfg.motor_scale}));
      end
      MUL_ERR_LO_T: begin
        mul_a = MUL_A_W'($signed({1'b0, err[CHUNK_W-1:0]}));
        mul_b = MUL_B_W'($signed({1'b0, cfg.tick_seconds}));
      end
      MUL_ERR_HI_T: begin
        mul_a = MUL_A_W'(err >>> CHUNK_W);
        mul_b = MUL_B_W'($signed({1'b0, cfg.tick_seconds}));
      end
      MUL_ERR_LO_P: begin
        mul_a = MUL_A_W'($signed({1'b0, err[CHUNK_W-1:0]}));
        mul_b = MUL_B_W'($signed({1'b0, cfg.gain_p}));
      end
      MUL_ERR_HI_P: begin
        mul_a = MUL_A_W'(err >>> CHUNK_W);
        mul_b = MUL_B_W'($signed({1'b0, cfg.gain_p}));
      end
      MUL_DER_LO: begin
        mul_a = MUL_A_W'($signed({1'b0, deriv[CHUNK_W-1:0]}));
        mul_b = MUL_B_W'($signed({1'b0, cfg.gain_d}));
      end
      MUL_DER_HI: begin
        mul_a = MUL_A_W'(deriv >>> CHUNK_W);
        mul_b = MUL_B_W'($signed({1'b0, cfg.gain_d}));
      end
      MUL_INT_LO: begin
        mul_a = MUL_A_W'($signed({1'b0, error_integral[CHUNK_W-1:0]}));
        mul_b = MUL_B_W'($signed({1'b0, cfg.gain_i}));
      end
      MUL_INT_HI: begin
        mul_a = MUL_A_W'(error_integral >>> CHUNK_W);
        mul_b = MUL_B_W'($signed({1'b0, cfg.gain_i}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext       = ACC_W'(prod);
  assign target_shifted = prod_ext <<< SHIFT;

  // The low bits of the product hold the fraction below Q.16, so the arithmetic
  // shift gives the floor.
  assign integ_sum = (INTEG_W + 1)'(error_integral) + (INTEG_W + 1)'(acc >>> 16);

  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
  end

  assign magnitude  = acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc);
  assign width_full = magnitude[ACC_W-1:CHUNK_W];

  always_comb begin
    if ((|width_full[ACC_W-CHUNK_W-1:LIMIT_W]) || (width_full[LIMIT_W-1:0] > cfg.drive_limit)) begin
      width_sat = cfg.drive_limit;
    end else begin
      width_sat = width_full[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_reading <= '0;
      have_previous    <= 1'b0;
      turn_offset      <= '0;
      encoder_total    <= '0;
      last_error       <= '0;
      error_integral   <= '0;
    end else begin
      if (cmd.ld_item) begin
        previous_reading <= sensor_angle;
        have_previous    <= 1'b1;
        turn_offset      <= turn_next;
        encoder_total    <= count_next;
      end
      if (cmd.ld_deriv) begin
        last_error <= err;
      end
      if (cmd.ld_integral) begin
        error_integral <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.ld_item) begin
      reading <= sensor_angle;
    end
    if (cmd.ld_target) begin
      target <= sat_angle(target_shifted);
    end
    if (cmd.ld_measured) begin
      measured <= sat_angle(prod_ext);
    end
    if (cmd.ld_err) begin
      err <= ERR_W'(target) - ERR_W'(measured);
    end
    if (cmd.ld_deriv) begin
      deriv <= DERIV_W'(err) - DERIV_W'(last_error);
    end
    case (cmd.acc_op)
      ACC_LOAD:   acc <= prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      ACC_ADD_HI: acc <= acc + (prod_ext <<< CHUNK_W);
      default:    acc <= acc;
    endcase
    if (cmd.ld_out) begin
      direction      <= !acc[ACC_W-1] && (|acc);
      drive_width    <= width_sat;
      target_angle   <= target;
      measured_angle <= measured;
    end
  end

endmodule

// ----- design/atpc_checker.sv -----
module atpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [atpc_pkg::OUT_W-1:0]  m_tdata
);
  import atpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed or dropped while stalled.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input still ready right after an item was taken.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("Block not idle and empty after reset.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("Result appeared while the block was idle.");

endmodule

bind angle_tracking_pid_controller atpc_checker u_atpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/tb_angle_tracking_pid_controller.sv -----
`timescale 1ns / 1ps

module tb_angle_tracking_pid_controller;
  import atpc_pkg::*;

  localparam int READING_W = SENSOR_BITS_DEF;
  localparam int TICK_DATA_W = ((READING_W + DELTA_W + 7) / 8) * 8;
  localparam longint READING_FULL = longint'(1) << READING_W;
  localparam longint READING_HALF = READING_FULL / 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int LONG_RUN_TURNS = 10;

  typedef struct packed {
    logic [READING_W-1:0]      sensor_angle;
    logic signed [DELTA_W-1:0] encoder_delta;
  } tick_t;

  typedef struct packed {
    logic                      direction;
    logic [LIMIT_W-1:0]        drive_width;
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [ANGLE_W-1:0] measured_angle;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // sensor_angle, encoder_delta
  logic [TICK_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // direction, drive_width, target_angle, measured_angle
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  angle_tracking_pid_controller dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  longint reg_zero = longint'(ZERO_POSITION_RST);
  longint reg_scale = longint'(MOTOR_SCALE_RST);
  longint reg_tick = longint'(TICK_SECONDS_RST);
  longint reg_kp = longint'(GAIN_P_RST);
  longint reg_ki = longint'(GAIN_I_RST);
  longint reg_kd = longint'(GAIN_D_RST);
  longint reg_limit = longint'(DRIVE_LIMIT_RST);

  logic [READING_W-1:0] last_reading = '0;
  bit reading_seen = 1'b0;
  longint turns = 0;
  longint count_total = 0;
  longint prior_error = 0;
  longint error_sum = 0;

  tick_t tick_queue[$];
  drive_t drive_queue[$];
  tick_t tick_on_bus;
  drive_t got, want;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  logic [15:0] rx_pattern = '1;
  logic [3:0] rx_phase = '0;
  logic [READING_W-1:0] walk_pos = '0;

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic drive_t compute_drive(input tick_t t);
    longint reading, prev, angle_q16, motor_q16, err, slope, i_term, i_cap, pid, mag, width;
    drive_t r;
    reading = longint'(t.sensor_angle);
    prev = reading_seen ? longint'(last_reading) : reg_zero;
    if (reading < prev && prev - reading > READING_HALF) begin
      turns = clamp_bits(turns + 1, TURN_W);
    end else if (prev < reading && reading - prev > READING_HALF) begin
      turns = clamp_bits(turns - 1, TURN_W);
    end
    last_reading = t.sensor_angle;
    reading_seen = 1'b1;
    angle_q16 = clamp_bits((reading - reg_zero + turns * READING_FULL) * DEG_FULL_TURN
                           * (longint'(1) << (16 - READING_W)), ANGLE_W);
    count_total = clamp_bits(count_total + longint'(signed'(t.encoder_delta)), COUNT_W);
    motor_q16 = clamp_bits(count_total * reg_scale, ANGLE_W);
    err = angle_q16 - motor_q16;
    slope = err - prior_error;
    prior_error = err;
    error_sum = clamp_bits(error_sum + ((err * reg_tick) >>> 16), INTEG_W);
    i_cap = longint'(1) <<< 60;
    if (reg_ki != 0 && (error_sum > i_cap / reg_ki || error_sum < -(i_cap / reg_ki))) begin
      i_term = (error_sum > 0) ? i_cap : -i_cap;
    end else begin
      i_term = error_sum * reg_ki;
    end
    pid = err * reg_kp + i_term + slope * reg_kd;
    mag = (pid > 0) ? pid : -pid;
    width = mag >>> 24;
    if (width > reg_limit) width = reg_limit;
    r.direction = (pid > 0);
    r.drive_width = LIMIT_W'(width);
    r.target_angle = ANGLE_W'(angle_q16);
    r.measured_angle = ANGLE_W'(motor_q16);
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ZERO_POSITION: reg_zero = longint'(value[ZERO_W-1:0]);
      CFG_MOTOR_SCALE:   reg_scale = longint'(value[SCALE_W-1:0]);
      CFG_TICK_SECONDS:  reg_tick = longint'(value[TICK_W-1:0]);
      CFG_GAIN_P:        reg_kp = longint'(value[GAIN_W-1:0]);
      CFG_GAIN_I:        reg_ki = longint'(value[GAIN_W-1:0]);
      CFG_GAIN_D:        reg_kd = longint'(value[GAIN_W-1:0]);
      CFG_DRIVE_LIMIT:   reg_limit = longint'(value[LIMIT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] zero, input logic [CFG_DATA_W-1:0] scale,
                           input logic [CFG_DATA_W-1:0] tick, input logic [CFG_DATA_W-1:0] kp,
                           input logic [CFG_DATA_W-1:0] ki, input logic [CFG_DATA_W-1:0] kd,
                           input logic [CFG_DATA_W-1:0] limit);
    write_reg(CFG_ZERO_POSITION, zero);
    write_reg(CFG_MOTOR_SCALE, scale);
    write_reg(CFG_TICK_SECONDS, tick);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_DRIVE_LIMIT, limit);
    @(negedge clk);
  endtask

  task automatic queue_tick(input logic [READING_W-1:0] angle, input logic signed [DELTA_W-1:0] delta);
    tick_t t;
    t.sensor_angle = angle;
    t.encoder_delta = delta;
    tick_queue.push_back(t);
  endtask

  // Mostly smooth shaft motion so that wraps come from real travel, with
  // occasional jumps of exactly half a turn and fully random readings.
  task automatic queue_random_ticks(input int n);
    int step;
    logic [DELTA_W-1:0] delta;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: walk_pos = READING_W'($urandom);
        1: walk_pos = walk_pos + READING_W'(READING_HALF);
        default: begin
          step = $urandom_range(0, 1400);
          walk_pos = walk_pos + READING_W'(step - 700);
        end
      endcase
      case ($urandom_range(0, 3))
        0: delta = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        1: delta = DELTA_W'(int'($urandom_range(0, 128)) - 64);
        default: delta = DELTA_W'($urandom);
      endcase
      queue_tick(walk_pos, delta);
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (tick_queue.size() != 0 || s_tvalid || drive_queue.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        drive_queue.push_back(compute_drive(tick_on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          tick_on_bus = tick_queue.pop_front();
          s_tdata <= TICK_DATA_W'({tick_on_bus.encoder_delta, tick_on_bus.sensor_angle});
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (gaps_on) begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.direction = m_tdata[0];
        got.drive_width = m_tdata[LIMIT_W:1];
        got.target_angle = m_tdata[LIMIT_W+ANGLE_W:LIMIT_W+1];
        got.measured_angle = m_tdata[LIMIT_W+2*ANGLE_W:LIMIT_W+ANGLE_W+1];
        if (drive_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: drive result with no tick behind it: %h", $realtime,
                                         m_tdata);
        end else begin
          want = drive_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: drive mismatch", $realtime);
              $display("  direction exp %0d got %0d", want.direction, got.direction);
              $display("  drive_width exp %0d got %0d", want.drive_width, got.drive_width);
              $display("  target    exp %0d got %0d", want.target_angle, got.target_angle);
              $display("  measured  exp %0d got %0d", want.measured_angle, got.measured_angle);
            end
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (rx_phase == 0) begin
        rx_pattern = (!stalls_on || $urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= rx_pattern[rx_phase];
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Upper bits of the write must be dropped; the spare index must change nothing.
    write_reg(CFG_ZERO_POSITION, 24'hABCBB8);
    write_reg(CFG_SPARE_INDEX, 24'hFFFFFF);
    @(negedge clk);
    queue_tick(12'd100, 16'sd0);
    queue_tick(12'd2148, 16'sd5);
    queue_tick(12'd100, -16'sd5);
    queue_tick(12'd2149, 16'sd32767);
    queue_tick(12'd100, 16'sh8000);
    queue_tick(12'd4095, 16'sd32767);
    queue_tick(12'd0, 16'sd32767);
    queue_tick(12'd4095, 16'sh8000);
    queue_tick(12'd3000, 16'sd0);
    queue_tick(12'd0, 16'sd0);
    queue_tick(12'd4095, -16'sd1);
    queue_tick(12'h555, 16'sh5555);
    queue_tick(12'hAAA, 16'shAAAA);
    queue_tick(12'h800, 16'sh8000);
    settle();

    write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    queue_random_ticks(5);
    settle();

    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    queue_random_ticks(120);
    settle();

    write_all(24'($urandom), MOTOR_SCALE_RST, CFG_DATA_W'(TICK_SECONDS_RST),
              CFG_DATA_W'(GAIN_P_RST), CFG_DATA_W'(GAIN_I_RST), 24'd64,
              CFG_DATA_W'(DRIVE_LIMIT_RST));
    hold_req = 1'b1;
    queue_random_ticks(140);
    settle();

    for (int p = 0; p < 3; p++) begin
      write_all(24'($urandom), 24'($urandom_range(0, 70000)), 24'($urandom),
                (p == 1) ? 24'($urandom_range(0, 1023)) : 24'($urandom),
                (p == 1) ? 24'($urandom_range(0, 255)) : 24'($urandom),
                (p == 1) ? 24'($urandom_range(0, 1023)) : 24'($urandom),
                (p == 0) ? 24'd1 : 24'($urandom));
      queue_random_ticks(90);
      settle();
    end

    // Steady forward rotation at full encoder rate with the largest motor scale:
    // the measured angle runs into saturation, then the count backs off.
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_all(24'd0, 24'hFFFFFF, 24'($urandom_range(0, 255)), 24'($urandom),
              24'($urandom_range(0, 16)), 24'($urandom), 24'h7FFF);
    for (int k = 0; k < LONG_RUN_TURNS; k++) begin
      queue_tick(12'd0, 16'sd32767);
      queue_tick(12'd2048, 16'sd32767);
      queue_tick(12'd4095, 16'sd32767);
    end
    for (int k = 0; k < 4; k++) begin
      queue_tick(READING_W'(k * 1000), 16'sh8000);
    end
    settle();

    repeat (40) @(negedge clk);
    if (mismatches == 0 && drive_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
